// ----- rtl/core/sfba_pkg.sv -----
// sfba_pkg: constants, word field widths, status codes and the size-class
// function of the segregated-fit block allocator
// no dependencies
package sfba_pkg;

   // arena geometry
   localparam int ARENA_LOG2   = 20;
   localparam int SIZE_CLASSES = 40;
   localparam int SLOT_W       = ARENA_LOG2 - 3;
   localparam int SZ_W         = ARENA_LOG2;
   localparam int WIDE_W       = ARENA_LOG2 + 2;
   localparam int BUMP_W       = ARENA_LOG2 + 1;
   localparam int LINK_W       = SLOT_W + 1;
   localparam int CLASS_W      = $clog2(SIZE_CLASSES + 1);
   localparam int SE_W         = 2 * SZ_W;
   localparam int LE_W         = 2 * LINK_W + 1;
   localparam int HDR_DEPTH    = 1 << SLOT_W;

   localparam logic [WIDE_W-1:0] HDR_BYTES   = WIDE_W'(32);
   localparam logic [WIDE_W-1:0] ARENA_BYTES = WIDE_W'(1) << ARENA_LOG2;

   // word field widths
   localparam int OPCODE_W   = 1;
   localparam int REQ_SIZE_W = 21;
   localparam int ADDR_W     = 20;
   localparam int STATUS_W   = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   // floor(log2(v)), clamped to the top class
   function automatic logic [CLASS_W-1:0] class_of(input logic [WIDE_W-1:0] v);
      logic [CLASS_W-1:0] c;
      c = '0;
      for (int i = 1; i < WIDE_W; i++) begin
         if (v[i]) c = CLASS_W'(i);
      end
      if (c > CLASS_W'(SIZE_CLASSES - 1)) c = CLASS_W'(SIZE_CLASSES - 1);
      return c;
   endfunction

endpackage

// ----- rtl/core/sfba_req_if.sv -----
// sfba_req_if: request channel of the allocator (valid, ready, request word)
// depends on sfba_pkg
interface sfba_req_if;
   import sfba_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [REQ_SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0]     block_address;

   modport source (output valid, output opcode, output request_size,
                   output block_address, input ready);
   modport sink   (input valid, input opcode, input request_size,
                   input block_address, output ready);
endinterface

// ----- rtl/core/sfba_rsp_if.sv -----
// sfba_rsp_if: response channel of the allocator (valid, ready, response word)
// depends on sfba_pkg
interface sfba_rsp_if;
   import sfba_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   payload_offset;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output payload_offset, output status, input ready);
   modport sink   (input valid, input payload_offset, input status, output ready);
endinterface

// ----- rtl/core/segregated_fit_block_allocator_core.sv -----
// segregated_fit_block_allocator_core: boundary-tag allocator with size-class
// free lists, a sequencer over header and class-head memories
// depends on sfba_pkg, sfba_req_if, sfba_rsp_if
//
// Usage: each request word carries an opcode (allocate or free), a size for
// allocate and a payload offset for free. Every request gives exactly one
// response word with a payload offset and a status.
// One request is worked at a time. req.ready is high while the sequencer is
// idle; the request then walks through read-modify-write steps on the header
// memories (one registered read port each). The work grows with the number of
// dependent header and list-link accesses: least for a zero size or an
// out-of-range free, more for a bump allocation, most for a free that merges
// both neighbours and moves a class.
// The response sits in an output register: a new request is taken while the
// previous response still waits. When the receiver stalls and a second
// response is ready, the sequencer holds it until the register frees.
// Reset (synchronous) clears the class bitmap, the bump offset and the
// control state at once; header memories are not cleared.
module segregated_fit_block_allocator_core (
   input logic      clock,
   input logic      reset,
   sfba_req_if.sink   req,
   sfba_rsp_if.source rsp
);
   import sfba_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE, S_DECODE, S_SEARCH, S_AL_HEAD, S_AL_BLK, S_SP_SIZE, S_SP_PUSH,
      S_SP_HDR, S_BP_RD, S_BP_LK, S_FR_RD, S_FR_CUR, S_FR_PRV, S_FR_NXT0,
      S_FR_NXT, S_FR_EVAL, S_FR_PF_NX, S_FR_PF_CL, S_FR_PF_PU, S_FR_NF_SZ,
      S_FR_NF_PU, S_OK, S_FREE_OK, S_DONE, S_UN0, S_UN1, S_UN_PV0, S_UN_PV1,
      S_UN_NX0, S_UN_NX1, S_UN_FR0, S_UN_FR1, S_PU0, S_PU1, S_PU2, S_PU3,
      S_FO0, S_FO1
   } state_type;

   state_type state_ff, ret_ff;

   // request and working registers
   logic [OPCODE_W-1:0]   op_ff;
   logic [REQ_SIZE_W-1:0] rsize_ff;
   logic [ADDR_W-1:0]     adr_ff;
   logic [BUMP_W-1:0]     bump_ff;
   logic [SZ_W-1:0]       size_ff, blk_ff, bsz_ff, bprev_ff, rsz_ff;
   logic [SZ_W-1:0]       cur_ff, prv_ff, csz_ff, ps_ff, psize_ff, pprev_ff;
   logic [SZ_W-1:0]       nsz_ff, mrg_ff;
   logic [WIDE_W-1:0]     rest_ff, nxt_ff;
   logic [CLASS_W-1:0]    k_ff, c_ff, oldc_ff, newc_ff;
   logic                  pf_ff, nf_ff;

   // subroutine arguments
   logic [SLOT_W-1:0]     un_slot_ff, pu_slot_ff;
   logic [CLASS_W-1:0]    un_class_ff, pu_class_ff;
   logic [WIDE_W-1:0]     fo_addr_ff;
   logic [SZ_W-1:0]       fo_size_ff;
   logic [LINK_W-1:0]     nx_ff, pv_ff, h_ff;

   // response registers
   logic                  rsp_valid_ff;
   logic [ADDR_W-1:0]     rsp_offset_ff, res_offset_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, res_status_ff;

   // memories and their ports
   logic [SE_W-1:0]       sz_mem [HDR_DEPTH];
   logic [LE_W-1:0]       lk_mem [HDR_DEPTH];
   logic [LINK_W-1:0]     hd_mem [SIZE_CLASSES];
   logic [SIZE_CLASSES-1:0] nonempty_ff;

   logic [SLOT_W-1:0]     sz_addr, lk_addr;
   logic [CLASS_W-1:0]    hd_addr;
   logic                  sz_we, lk_we, hd_we;
   logic [SE_W-1:0]       sz_wdata, sz_rd_ff;
   logic [LE_W-1:0]       lk_wdata, lk_rd_ff;
   logic [LINK_W-1:0]     hd_wdata, hd_rd_ff;
   logic                  hd_vld_ff;

   // read data views
   logic [SZ_W-1:0]       rd_size, rd_prev;
   logic                  rd_free;
   logic [LINK_W-1:0]     rd_next, rd_lprev, head_rd;
   logic                  un_hit;
   logic                  found;
   logic [CLASS_W-1:0]    found_class;
   logic [SZ_W-1:0]       fr_prv, pf_mrg, nf_mrg;
   logic                  fr_pf_cand;

   assign rd_size  = sz_rd_ff[SE_W-1:SZ_W];
   assign rd_prev  = sz_rd_ff[SZ_W-1:0];
   assign rd_free  = lk_rd_ff[LE_W-1];
   assign rd_next  = lk_rd_ff[2*LINK_W-1:LINK_W];
   assign rd_lprev = lk_rd_ff[LINK_W-1:0];
   assign head_rd  = hd_vld_ff ? hd_rd_ff : '0;
   assign un_hit   = (head_rd == LINK_W'({1'b0, un_slot_ff} + 1'b1));

   // free path arithmetic
   assign fr_pf_cand = (rd_prev != '0) &&
                       (WIDE_W'(rd_prev) + HDR_BYTES <= WIDE_W'(cur_ff));
   assign fr_prv     = SZ_W'(WIDE_W'(cur_ff) - HDR_BYTES - WIDE_W'(rd_prev));
   assign pf_mrg     = SZ_W'(WIDE_W'(psize_ff) + HDR_BYTES + WIDE_W'(csz_ff) +
                             (nf_ff ? (HDR_BYTES + WIDE_W'(nsz_ff)) : '0));
   assign nf_mrg     = SZ_W'(WIDE_W'(csz_ff) + HDR_BYTES + WIDE_W'(nsz_ff));

   // lowest non-empty class at or above k
   always_comb begin
      found       = 1'b0;
      found_class = '0;
      for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
         if (nonempty_ff[i] && (CLASS_W'(i) >= k_ff)) begin
            found       = 1'b1;
            found_class = CLASS_W'(i);
         end
      end
   end

   // memory port decode
   always_comb begin
      sz_addr  = '0;
      sz_we    = 1'b0;
      sz_wdata = '0;
      lk_addr  = '0;
      lk_we    = 1'b0;
      lk_wdata = '0;
      hd_addr  = '0;
      hd_we    = 1'b0;
      hd_wdata = '0;
      case (state_ff)
         S_SEARCH: begin
            hd_addr = found_class;
            sz_addr = bump_ff[ARENA_LOG2-1:3];
         end
         S_AL_HEAD: sz_addr = SLOT_W'(head_rd - 1'b1);
         S_SP_SIZE: begin
            sz_we    = 1'b1;
            sz_addr  = rest_ff[ARENA_LOG2-1:3];
            sz_wdata = {SZ_W'(bsz_ff - SZ_W'(HDR_BYTES) - size_ff), size_ff};
         end
         S_SP_HDR: begin
            sz_we    = 1'b1;
            sz_addr  = blk_ff[ARENA_LOG2-1:3];
            sz_wdata = {size_ff, bprev_ff};
         end
         S_BP_RD: begin
            sz_we    = 1'b1;
            sz_addr  = blk_ff[ARENA_LOG2-1:3];
            sz_wdata = {size_ff, (blk_ff == '0) ? SZ_W'(0) : rd_prev};
            lk_addr  = blk_ff[ARENA_LOG2-1:3];
         end
         S_BP_LK: begin
            lk_we    = 1'b1;
            lk_addr  = blk_ff[ARENA_LOG2-1:3];
            lk_wdata = {1'b0, lk_rd_ff[LE_W-2:0]};
         end
         S_FR_RD: sz_addr = cur_ff[ARENA_LOG2-1:3];
         S_FR_CUR: begin
            sz_addr = fr_prv[ARENA_LOG2-1:3];
            lk_addr = fr_prv[ARENA_LOG2-1:3];
         end
         S_FR_NXT0: begin
            sz_addr = nxt_ff[ARENA_LOG2-1:3];
            lk_addr = nxt_ff[ARENA_LOG2-1:3];
         end
         S_FR_EVAL: begin
            sz_addr  = prv_ff[ARENA_LOG2-1:3];
            sz_we    = pf_ff;
            sz_wdata = {pf_mrg, pprev_ff};
         end
         S_FR_NF_SZ: begin
            sz_we    = 1'b1;
            sz_addr  = cur_ff[ARENA_LOG2-1:3];
            sz_wdata = {nf_mrg, ps_ff};
         end
         S_UN0: begin
            lk_addr = un_slot_ff;
            hd_addr = un_class_ff;
         end
         S_UN1: begin
            hd_addr  = un_class_ff;
            hd_we    = un_hit;
            hd_wdata = rd_next;
         end
         S_UN_PV0: lk_addr = SLOT_W'(pv_ff - 1'b1);
         S_UN_PV1: begin
            lk_we    = 1'b1;
            lk_addr  = SLOT_W'(pv_ff - 1'b1);
            lk_wdata = {rd_free, nx_ff, rd_lprev};
         end
         S_UN_NX0: lk_addr = SLOT_W'(nx_ff - 1'b1);
         S_UN_NX1: begin
            lk_we    = 1'b1;
            lk_addr  = SLOT_W'(nx_ff - 1'b1);
            lk_wdata = {rd_free, rd_next, pv_ff};
         end
         S_UN_FR0: lk_addr = un_slot_ff;
         S_UN_FR1: begin
            lk_we    = 1'b1;
            lk_addr  = un_slot_ff;
            lk_wdata = {1'b0, lk_rd_ff[LE_W-2:0]};
         end
         S_PU0: hd_addr = pu_class_ff;
         S_PU1: begin
            lk_we    = 1'b1;
            lk_addr  = pu_slot_ff;
            lk_wdata = {1'b1, head_rd, LINK_W'(0)};
            hd_we    = 1'b1;
            hd_addr  = pu_class_ff;
            hd_wdata = LINK_W'({1'b0, pu_slot_ff} + 1'b1);
         end
         S_PU2: lk_addr = SLOT_W'(h_ff - 1'b1);
         S_PU3: begin
            lk_we    = 1'b1;
            lk_addr  = SLOT_W'(h_ff - 1'b1);
            lk_wdata = {rd_free, rd_next, LINK_W'({1'b0, pu_slot_ff} + 1'b1)};
         end
         S_FO0: sz_addr = fo_addr_ff[ARENA_LOG2-1:3];
         S_FO1: begin
            sz_we    = 1'b1;
            sz_addr  = fo_addr_ff[ARENA_LOG2-1:3];
            sz_wdata = {rd_size, fo_size_ff};
         end
         default: begin
         end
      endcase
   end

   // header and class-head memories, registered reads
   always_ff @(posedge clock) begin
      if (sz_we) sz_mem[sz_addr] <= sz_wdata;
      sz_rd_ff <= sz_mem[sz_addr];
      if (lk_we) lk_mem[lk_addr] <= lk_wdata;
      lk_rd_ff <= lk_mem[lk_addr];
      if (hd_we) hd_mem[hd_addr] <= hd_wdata;
      hd_rd_ff <= hd_mem[hd_addr];
   end

   // class bitmap: valid bits of the class heads
   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         hd_vld_ff   <= 1'b0;
      end else begin
         hd_vld_ff <= nonempty_ff[hd_addr];
         if (hd_we) nonempty_ff[hd_addr] <= (hd_wdata != '0);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  op_ff    <= req.opcode;
                  rsize_ff <= req.request_size;
                  adr_ff   <= req.block_address;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               res_offset_ff <= '0;
               if (op_ff == OP_ALLOC) begin
                  if (((WIDE_W'(rsize_ff) + WIDE_W'(7)) & ~WIDE_W'(7)) == '0) begin
                     res_status_ff <= ST_ZERO_SIZE;
                     state_ff      <= S_DONE;
                  end else if (((WIDE_W'(rsize_ff) + WIDE_W'(7)) & ~WIDE_W'(7)) >
                               ARENA_BYTES - HDR_BYTES) begin
                     res_status_ff <= ST_NO_SPACE;
                     state_ff      <= S_DONE;
                  end else begin
                     size_ff  <= SZ_W'((WIDE_W'(rsize_ff) + WIDE_W'(7)) & ~WIDE_W'(7));
                     k_ff     <= CLASS_W'(class_of((WIDE_W'(rsize_ff) + WIDE_W'(7)) &
                                                   ~WIDE_W'(7)) + 1'b1);
                     state_ff <= S_SEARCH;
                  end
               end else begin
                  if ((WIDE_W'(adr_ff) < HDR_BYTES) ||
                      (WIDE_W'(adr_ff) >= WIDE_W'(bump_ff))) begin
                     res_status_ff <= ST_RANGE;
                     state_ff      <= S_DONE;
                  end else begin
                     cur_ff   <= SZ_W'({adr_ff[ADDR_W-1:3], 3'b000} - SZ_W'(HDR_BYTES));
                     state_ff <= S_FR_RD;
                  end
               end
            end
            // allocate: list head or bump carve
            S_SEARCH: begin
               if (found) begin
                  c_ff     <= found_class;
                  state_ff <= S_AL_HEAD;
               end else if (WIDE_W'(bump_ff) + HDR_BYTES + WIDE_W'(size_ff) >
                            ARENA_BYTES) begin
                  res_status_ff <= ST_NO_SPACE;
                  state_ff      <= S_DONE;
               end else begin
                  blk_ff   <= bump_ff[SZ_W-1:0];
                  state_ff <= S_BP_RD;
               end
            end
            S_AL_HEAD: begin
               blk_ff   <= {SLOT_W'(head_rd - 1'b1), 3'b000};
               state_ff <= S_AL_BLK;
            end
            S_AL_BLK: begin
               bsz_ff     <= rd_size;
               bprev_ff   <= rd_prev;
               un_slot_ff <= blk_ff[ARENA_LOG2-1:3];
               state_ff   <= S_UN0;
               if (WIDE_W'(rd_size) > HDR_BYTES + WIDE_W'(size_ff)) begin
                  rest_ff     <= WIDE_W'(blk_ff) + HDR_BYTES + WIDE_W'(size_ff);
                  un_class_ff <= class_of(WIDE_W'(rd_size));
                  ret_ff      <= S_SP_SIZE;
               end else begin
                  un_class_ff <= c_ff;
                  ret_ff      <= S_OK;
               end
            end
            S_SP_SIZE: begin
               rsz_ff     <= SZ_W'(bsz_ff - SZ_W'(HDR_BYTES) - size_ff);
               fo_addr_ff <= rest_ff + HDR_BYTES +
                             WIDE_W'(SZ_W'(bsz_ff - SZ_W'(HDR_BYTES) - size_ff));
               fo_size_ff <= SZ_W'(bsz_ff - SZ_W'(HDR_BYTES) - size_ff);
               ret_ff     <= S_SP_PUSH;
               state_ff   <= S_FO0;
            end
            S_SP_PUSH: begin
               pu_slot_ff  <= rest_ff[ARENA_LOG2-1:3];
               pu_class_ff <= class_of(WIDE_W'(rsz_ff));
               ret_ff      <= S_SP_HDR;
               state_ff    <= S_PU0;
            end
            S_SP_HDR: state_ff <= S_OK;
            S_BP_RD:  state_ff <= S_BP_LK;
            S_BP_LK: begin
               bump_ff    <= BUMP_W'(WIDE_W'(blk_ff) + HDR_BYTES + WIDE_W'(size_ff));
               fo_addr_ff <= WIDE_W'(blk_ff) + HDR_BYTES + WIDE_W'(size_ff);
               fo_size_ff <= size_ff;
               ret_ff     <= S_OK;
               state_ff   <= S_FO0;
            end
            S_OK: begin
               res_offset_ff <= ADDR_W'(WIDE_W'(blk_ff) + HDR_BYTES);
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
            end
            // free: gather neighbours
            S_FR_RD: state_ff <= S_FR_CUR;
            S_FR_CUR: begin
               csz_ff   <= rd_size;
               ps_ff    <= rd_prev;
               nxt_ff   <= WIDE_W'(cur_ff) + HDR_BYTES + WIDE_W'(rd_size);
               prv_ff   <= fr_prv;
               pf_ff    <= 1'b0;
               state_ff <= fr_pf_cand ? S_FR_PRV : S_FR_NXT0;
            end
            S_FR_PRV: begin
               pf_ff    <= rd_free;
               psize_ff <= rd_size;
               pprev_ff <= rd_prev;
               state_ff <= S_FR_NXT0;
            end
            S_FR_NXT0: begin
               nf_ff    <= 1'b0;
               state_ff <= (nxt_ff < WIDE_W'(bump_ff)) ? S_FR_NXT : S_FR_EVAL;
            end
            S_FR_NXT: begin
               nf_ff    <= rd_free;
               nsz_ff   <= rd_size;
               state_ff <= S_FR_EVAL;
            end
            S_FR_EVAL: begin
               if (pf_ff) begin
                  mrg_ff     <= pf_mrg;
                  oldc_ff    <= class_of(WIDE_W'(psize_ff));
                  newc_ff    <= class_of(WIDE_W'(pf_mrg));
                  fo_addr_ff <= WIDE_W'(prv_ff) + HDR_BYTES + WIDE_W'(pf_mrg);
                  fo_size_ff <= pf_mrg;
                  ret_ff     <= S_FR_PF_NX;
                  state_ff   <= S_FO0;
               end else if (nf_ff) begin
                  un_slot_ff  <= nxt_ff[ARENA_LOG2-1:3];
                  un_class_ff <= class_of(WIDE_W'(nsz_ff));
                  ret_ff      <= S_FR_NF_SZ;
                  state_ff    <= S_UN0;
               end else begin
                  pu_slot_ff  <= cur_ff[ARENA_LOG2-1:3];
                  pu_class_ff <= class_of(WIDE_W'(csz_ff));
                  ret_ff      <= S_FREE_OK;
                  state_ff    <= S_PU0;
               end
            end
            S_FR_PF_NX: begin
               if (nf_ff) begin
                  un_slot_ff  <= nxt_ff[ARENA_LOG2-1:3];
                  un_class_ff <= class_of(WIDE_W'(nsz_ff));
                  ret_ff      <= S_FR_PF_CL;
                  state_ff    <= S_UN0;
               end else begin
                  state_ff <= S_FR_PF_CL;
               end
            end
            S_FR_PF_CL: begin
               if (oldc_ff != newc_ff) begin
                  un_slot_ff  <= prv_ff[ARENA_LOG2-1:3];
                  un_class_ff <= oldc_ff;
                  ret_ff      <= S_FR_PF_PU;
                  state_ff    <= S_UN0;
               end else begin
                  state_ff <= S_FREE_OK;
               end
            end
            S_FR_PF_PU: begin
               pu_slot_ff  <= prv_ff[ARENA_LOG2-1:3];
               pu_class_ff <= newc_ff;
               ret_ff      <= S_FREE_OK;
               state_ff    <= S_PU0;
            end
            S_FR_NF_SZ: begin
               mrg_ff     <= nf_mrg;
               fo_addr_ff <= WIDE_W'(cur_ff) + HDR_BYTES + WIDE_W'(nf_mrg);
               fo_size_ff <= nf_mrg;
               ret_ff     <= S_FR_NF_PU;
               state_ff   <= S_FO0;
            end
            S_FR_NF_PU: begin
               pu_slot_ff  <= cur_ff[ARENA_LOG2-1:3];
               pu_class_ff <= class_of(WIDE_W'(mrg_ff));
               ret_ff      <= S_FREE_OK;
               state_ff    <= S_PU0;
            end
            S_FREE_OK: begin
               res_offset_ff <= '0;
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
            end
            // hand the word to the output register
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_offset_ff <= res_offset_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            // unlink a block from its class list
            S_UN0: state_ff <= S_UN1;
            S_UN1: begin
               nx_ff <= rd_next;
               if (un_hit) begin
                  pv_ff    <= '0;
                  state_ff <= (rd_next != '0) ? S_UN_NX0 : S_UN_FR0;
               end else begin
                  pv_ff <= rd_lprev;
                  if (rd_lprev != '0)     state_ff <= S_UN_PV0;
                  else if (rd_next != '0) state_ff <= S_UN_NX0;
                  else                    state_ff <= S_UN_FR0;
               end
            end
            S_UN_PV0: state_ff <= S_UN_PV1;
            S_UN_PV1: state_ff <= (nx_ff != '0) ? S_UN_NX0 : S_UN_FR0;
            S_UN_NX0: state_ff <= S_UN_NX1;
            S_UN_NX1: state_ff <= S_UN_FR0;
            S_UN_FR0: state_ff <= S_UN_FR1;
            S_UN_FR1: state_ff <= ret_ff;
            // push a block on its class list
            S_PU0: state_ff <= S_PU1;
            S_PU1: begin
               h_ff     <= head_rd;
               state_ff <= (head_rd != '0) ? S_PU2 : ret_ff;
            end
            S_PU2: state_ff <= S_PU3;
            S_PU3: state_ff <= ret_ff;
            // previous-size tag of the following block
            S_FO0: state_ff <= (fo_addr_ff < ARENA_BYTES) ? S_FO1 : ret_ff;
            S_FO1: state_ff <= ret_ff;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ports
   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.payload_offset = rsp_offset_ff;
   assign rsp.status         = rsp_status_ff;

`ifndef SYNTH
   // bump offset never runs past the arena end
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(bump_ff) <= ARENA_BYTES)
      else $error("bump offset beyond arena");

   // a class-head write leaves the bitmap matching the stored head
   a_head_bitmap: assert property (@(posedge clock) disable iff (reset)
      hd_we |=> (nonempty_ff[$past(hd_addr)] == ($past(hd_wdata) != '0)))
      else $error("class bitmap out of step with class head");

   // status codes match the operation
   a_status_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |->
         ((op_ff == OP_ALLOC) || (res_status_ff == ST_OK) || (res_status_ff == ST_RANGE)) &&
         ((op_ff == OP_FREE) || (res_status_ff != ST_RANGE)))
      else $error("status does not fit operation");

   // a good allocation never returns offset zero
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (op_ff == OP_ALLOC) && (res_status_ff == ST_OK)) |->
         (res_offset_ff != '0))
      else $error("allocation returned offset zero");
`endif

endmodule

// ----- verif/segregated_fit_block_allocator_core_test.sv -----
// segregated_fit_block_allocator_core_test: self-checking bench for the allocator core,
// predicting every response word from its own model of headers and class lists
// depends on sfba_pkg, sfba_req_if, sfba_rsp_if and segregated_fit_block_allocator_core
module segregated_fit_block_allocator_core_test;
   import sfba_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   // model of the arena, its headers and the size-class lists
   class free_list_scoreboard;
      typedef struct {
         logic [ADDR_W-1:0]   off;
         logic [STATUS_W-1:0] st;
      } resp_t;

      localparam longint unsigned ARENA = 64'd1 << ARENA_LOG2;
      localparam longint unsigned HDR   = 64'd32;
      localparam longint unsigned SMASK = ARENA - 1;
      localparam int unsigned     LMASK = HDR_DEPTH - 1;

      longint unsigned blk_size[HDR_DEPTH];
      longint unsigned blk_prev[HDR_DEPTH];
      int unsigned     lnk_next[HDR_DEPTH];
      int unsigned     lnk_prev[HDR_DEPTH];
      bit              lnk_free[HDR_DEPTH];
      int unsigned     class_head[SIZE_CLASSES];
      int unsigned     lowest_from[SIZE_CLASSES];
      longint unsigned bump;
      resp_t           pending[$];
      int              errors;

      function new();
         for (int i = 0; i < SIZE_CLASSES; i++) begin
            class_head[i]  = 0;
            lowest_from[i] = SIZE_CLASSES;
         end
         bump   = 0;
         errors = 0;
      endfunction

      function int unsigned slot(longint unsigned a);
         return int'((a >> 3) & LMASK);
      endfunction

      function int unsigned lslot(int unsigned l);
         return (l - 1) & LMASK;
      endfunction

      function int unsigned size_class(longint unsigned v);
         int unsigned c;
         c = 0;
         while (v > 1) begin
            v = v >> 1;
            c++;
         end
         if (c > SIZE_CLASSES - 1) c = SIZE_CLASSES - 1;
         return c;
      endfunction

      function void set_follower_prev(longint unsigned a);
         longint unsigned sz, nx;
         sz = blk_size[slot(a)];
         nx = a + HDR + sz;
         if (nx < ARENA) blk_prev[slot(nx)] = sz;
      endfunction

      function void push(longint unsigned a, int unsigned c);
         int unsigned s;
         s = slot(a);
         lnk_prev[s] = 0;
         lnk_next[s] = class_head[c];
         if (class_head[c] != 0) lnk_prev[lslot(class_head[c])] = s + 1;
         class_head[c] = s + 1;
         lnk_free[s]   = 1;
         for (int i = 0; i <= c; i++)
            if (c < lowest_from[i]) lowest_from[i] = c;
      endfunction

      function void unlink(longint unsigned a, int unsigned c);
         int unsigned s, nx, pv, up;
         s  = slot(a);
         nx = lnk_next[s];
         pv = lnk_prev[s];
         if (class_head[c] == s + 1) begin
            class_head[c] = nx;
            if (nx != 0) begin
               lnk_prev[lslot(nx)] = 0;
            end else begin
               up = (c + 1 < SIZE_CLASSES) ? lowest_from[c + 1] : SIZE_CLASSES;
               for (int i = 0; i <= c; i++)
                  if (lowest_from[i] == c) lowest_from[i] = up;
            end
         end else begin
            if (pv != 0) lnk_next[lslot(pv)] = nx;
            if (nx != 0) lnk_prev[lslot(nx)] = pv;
         end
         lnk_free[s] = 0;
      endfunction

      // coalesce a released block with free neighbours
      function void release_block(longint unsigned cur);
         int unsigned     cs, p, oldc, newc;
         longint unsigned csz, ps, prv, nxt, add, nsz;
         bit              pf, nf;
         cs  = slot(cur);
         csz = blk_size[cs];
         ps  = blk_prev[cs];
         prv = 0;
         nxt = cur + HDR + csz;
         pf  = 0;
         nf  = 0;
         if (ps != 0 && ps + HDR <= cur) begin
            prv = cur - HDR - ps;
            pf  = lnk_free[slot(prv)];
         end
         if (nxt < bump) nf = lnk_free[slot(nxt)];
         if (pf) begin
            p    = slot(prv);
            oldc = size_class(blk_size[p]);
            add  = HDR + csz;
            if (nf) add += HDR + blk_size[slot(nxt)];
            blk_size[p] = (blk_size[p] + add) & SMASK;
            newc = size_class(blk_size[p]);
            set_follower_prev(prv);
            if (nf) unlink(nxt, size_class(blk_size[slot(nxt)]));
            if (oldc != newc) begin
               unlink(prv, oldc);
               push(prv, newc);
            end
         end else if (nf) begin
            nsz = blk_size[slot(nxt)];
            unlink(nxt, size_class(nsz));
            blk_size[cs] = (csz + HDR + nsz) & SMASK;
            set_follower_prev(cur);
            push(cur, size_class(blk_size[cs]));
         end else begin
            push(cur, size_class(csz));
         end
      endfunction

      // work out the response to an accepted request word
      function resp_t predict(logic op, longint unsigned req, longint unsigned adr);
         resp_t           r;
         longint unsigned size, blk, bsz, rest;
         int unsigned     k, c, h, s, rs;
         r.off = '0;
         r.st  = ST_OK;
         if (op == OP_ALLOC) begin
            size = (req + 7) & ~64'd7;
            if (size == 0) begin
               r.st = ST_ZERO_SIZE;
               return r;
            end
            if (size > ARENA - HDR) begin
               r.st = ST_NO_SPACE;
               return r;
            end
            k = size_class(size) + 1;
            if (k < SIZE_CLASSES && lowest_from[k] < SIZE_CLASSES) begin
               c = lowest_from[k];
               h = class_head[c];
               if (h != 0) begin
                  s   = lslot(h);
                  bsz = blk_size[s];
                  blk = longint'(s) << 3;
                  if (bsz > HDR + size) begin
                     rest = blk + HDR + size;
                     rs   = slot(rest);
                     unlink(blk, size_class(bsz));
                     blk_size[rs] = bsz - HDR - size;
                     blk_prev[rs] = size;
                     set_follower_prev(rest);
                     push(rest, size_class(blk_size[rs]));
                     blk_size[s] = size;
                  end else begin
                     unlink(blk, c);
                  end
                  r.off = ADDR_W'(blk + HDR);
                  return r;
               end
            end
            blk = bump;
            if (blk + HDR + size > ARENA) begin
               r.st = ST_NO_SPACE;
               return r;
            end
            blk_size[slot(blk)] = size;
            if (blk == 0) blk_prev[slot(blk)] = 0;
            lnk_free[slot(blk)] = 0;
            set_follower_prev(blk);
            bump  = blk + HDR + size;
            r.off = ADDR_W'(blk + HDR);
            return r;
         end
         if (adr < HDR || adr >= bump) begin
            r.st = ST_RANGE;
            return r;
         end
         release_block((adr & ~64'd7) - HDR);
         return r;
      endfunction

      function resp_t note(logic op, longint unsigned req, longint unsigned adr);
         resp_t r;
         r = predict(op, req, adr);
         pending.push_back(r);
         return r;
      endfunction

      function void check(logic [ADDR_W-1:0] off, logic [STATUS_W-1:0] st);
         resp_t e;
         if (pending.size() == 0) begin
            $error("response word with none outstanding: payload_offset %0d status %0d",
                   off, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (off !== e.off) begin
            $error("payload_offset: expected %0d, actual %0d", e.off, off);
            errors++;
         end
         if (st !== e.st) begin
            $error("status: expected %0d, actual %0d", e.st, st);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;

   free_list_scoreboard    sb = new();
   logic [ADDR_W-1:0]      live[$];

   sfba_req_if req ();
   sfba_rsp_if rsp ();

   segregated_fit_block_allocator_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check(rsp.payload_offset, rsp.status);
      rsp.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // drive one request word and wait until it is taken
   task automatic send_word(input logic op, input logic [REQ_SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] adr,
                            output free_list_scoreboard::resp_t r);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.opcode        <= op;
      req.request_size  <= size;
      req.block_address <= adr;
      do @(posedge clock); while (!req.ready);
      r = sb.note(op, size, adr);
      if (op == OP_ALLOC && r.st == ST_OK) live.push_back(r.off);
   endtask

   task automatic alloc_word(input logic [REQ_SIZE_W-1:0] size,
                             output logic [ADDR_W-1:0] off);
      free_list_scoreboard::resp_t r;
      send_word(OP_ALLOC, size, '0, r);
      off = r.off;
   endtask

   task automatic free_word(input logic [ADDR_W-1:0] adr);
      free_list_scoreboard::resp_t r;
      for (int i = 0; i < live.size(); i++)
         if (live[i] == {adr[ADDR_W-1:3], 3'b000}) begin
            live.delete(i);
            break;
         end
      send_word(OP_FREE, '0, adr, r);
   endtask

   // one random word: mostly allocations and frees of live blocks, some noise
   task automatic random_word();
      int                    r;
      int                    idx;
      logic [REQ_SIZE_W-1:0] size;
      logic [ADDR_W-1:0]     adr, off;
      r = $urandom_range(99);
      if (r < 35 && live.size() > 0) begin
         idx = $urandom_range(live.size() - 1);
         adr = live[idx] | ADDR_W'($urandom_range(7));
         free_word(adr);
      end else if (r < 45) begin
         if ($urandom_range(1) == 0 || sb.bump >= (64'd1 << ARENA_LOG2))
            adr = ADDR_W'($urandom_range(31));
         else
            adr = ADDR_W'($urandom_range((1 << ARENA_LOG2) - 1, int'(sb.bump)));
         free_word(adr);
      end else begin
         r = $urandom_range(99);
         if (r < 4)       size = '0;
         else if (r < 10) size = REQ_SIZE_W'($urandom_range((1 << REQ_SIZE_W) - 1));
         else if (r < 20) size = REQ_SIZE_W'($urandom_range(65536, 1));
         else             size = REQ_SIZE_W'($urandom_range(1024, 1));
         alloc_word(size, off);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] a, b, c, d;
      req.valid         = 1'b0;
      req.opcode        = OP_ALLOC;
      req.request_size  = '0;
      req.block_address = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range checks, size limits, splits and both-sided merges
      free_word('0);
      alloc_word('0, a);
      alloc_word(REQ_SIZE_W'(1048576), a);
      alloc_word({REQ_SIZE_W{1'b1}}, a);
      alloc_word(REQ_SIZE_W'(1048545), a);
      alloc_word(REQ_SIZE_W'(1), a);
      alloc_word(REQ_SIZE_W'(100), b);
      alloc_word(REQ_SIZE_W'(8), c);
      alloc_word(REQ_SIZE_W'(200), d);
      free_word(a);
      free_word(c);
      free_word(b | ADDR_W'(5));
      alloc_word(REQ_SIZE_W'(16), a);
      alloc_word(REQ_SIZE_W'(64), b);
      free_word(d);
      free_word(ADDR_W'(31));
      free_word({ADDR_W{1'b1}});
      alloc_word(REQ_SIZE_W'(300), c);
      free_word(b);
      free_word(a | ADDR_W'(7));

      // random, three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
         recv_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
         for (int n = 0; n < 380; n++) begin
            random_word();
            // hold off until the pipe drains
            if (n == 190) begin
               req.valid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
      end

      // repeated free of one block
      alloc_word(REQ_SIZE_W'(40), a);
      alloc_word(REQ_SIZE_W'(40), b);
      free_word(a);
      free_word(a);
      req.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sfba_pkg.sv
rtl/core/sfba_req_if.sv
rtl/core/sfba_rsp_if.sv
rtl/core/segregated_fit_block_allocator_core.sv
verif/segregated_fit_block_allocator_core_test.sv
